// ===== design/s256h_pkg.sv =====
// ----------------------------------------------------------------------------
// s256h_pkg
// types, constants and round functions shared by the sha-256 hasher
// ----------------------------------------------------------------------------
package s256h_pkg;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       start;
    logic       init_chain;
  } s256h_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_START,
    ST_WAIT,
    ST_OUT
  } s256h_state_t;

  localparam logic [7:0]  PAD_MARK   = 8'h80;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  LAST_POS   = 6'd63;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_WORD  = 3'd7;
  localparam logic [63:0] BYTE_BITS  = 64'd8;

  localparam hash_t IV_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== design/s256h_core.sv =====
// ----------------------------------------------------------------------------
// s256h_core
// message window, one-round-per-cycle compression unit and chaining value
// ----------------------------------------------------------------------------
module s256h_core
  import s256h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  s256h_ctrl_t ctrl,
  output logic        done,
  output hash_t       chain
);

  logic [511:0] win;
  hash_t        vars;
  hash_t        vars_next;
  logic [5:0]   cnt;
  logic         run;
  logic         fin;
  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign w_cur = win[511:480];
  assign w_new = small_sigma1(win[63:32]) + win[223:192] +
                 small_sigma0(win[479:448]) + w_cur;

  always_comb begin
    t1 = vars[7] + big_sigma1(vars[4]) +
         ((vars[4] & vars[5]) ^ (~vars[4] & vars[6])) + K_TABLE[cnt] + w_cur;
    t2 = big_sigma0(vars[0]) +
         ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
    vars_next[0] = t1 + t2;
    vars_next[1] = vars[0];
    vars_next[2] = vars[1];
    vars_next[3] = vars[2];
    vars_next[4] = vars[3] + t1;
    vars_next[5] = vars[4];
    vars_next[6] = vars[5];
    vars_next[7] = vars[6];
  end

  assign done = fin;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      fin   <= 1'b0;
      cnt   <= '0;
      chain <= IV_HASH;
    end else begin
      fin <= 1'b0;
      if (ctrl.start) begin
        run <= 1'b1;
        cnt <= '0;
      end
      if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == LAST_ROUND) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (ctrl.init_chain) begin
        chain <= IV_HASH;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      win <= {win[503:0], ctrl.shift_byte};
    end else if (run) begin
      win <= {win[479:0], w_new};
    end
    if (ctrl.start) begin
      vars <= chain;
    end else if (run) begin
      vars <= vars_next;
    end
  end

endmodule

// ===== design/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// sha-256 over a byte stream, digest words out at message end
// ----------------------------------------------------------------------------
// Each accepted request with a byte shifts it into the message window. The
// request that completes a 64-byte block is followed by a busy compression in
// the single round unit (load, 64 rounds, chaining add). At message end the
// padding, 0x80, zeros and the 64-bit length, goes in one byte per cycle with
// one or two further compressions, then the eight digest words leave in order,
// one per cycle while m_tready is high. s_tready is low from the request that
// fills a block until its compression is done, and from the request that ends
// a message until the last digest word is taken.
module sha256_stream_hasher
  import s256h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [2:0]  m_tuser,   // word_index
  output logic        m_tlast    // final_word
);

  s256h_state_t state, state_next;
  logic [5:0]   pos, pos_next;
  logic [63:0]  len_bits, len_bits_next;
  logic         pad_active, pad_active_next;
  logic         mark_done, mark_done_next;
  logic         len_phase, len_phase_next;
  logic [2:0]   out_idx, out_idx_next;
  s256h_ctrl_t  ctrl;
  logic         core_done;
  hash_t        chain;
  logic         in_acc;
  logic         out_acc;

  s256h_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .done  (core_done),
    .chain (chain)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = chain[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == LAST_WORD);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      len_bits   <= '0;
      pad_active <= 1'b0;
      mark_done  <= 1'b0;
      len_phase  <= 1'b0;
      out_idx    <= '0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      len_bits   <= len_bits_next;
      pad_active <= pad_active_next;
      mark_done  <= mark_done_next;
      len_phase  <= len_phase_next;
      out_idx    <= out_idx_next;
    end
  end

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    len_bits_next   = len_bits;
    pad_active_next = pad_active;
    mark_done_next  = mark_done;
    len_phase_next  = len_phase;
    out_idx_next    = out_idx;
    ctrl            = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser) begin
            ctrl.shift_en   = 1'b1;
            ctrl.shift_byte = s_tdata;
            pos_next        = pos + 6'd1;
            len_bits_next   = len_bits + BYTE_BITS;
          end
          if (s_tuser && pos == LAST_POS) begin
            pad_active_next = s_tlast;
            state_next      = ST_START;
          end else if (s_tlast) begin
            pad_active_next = 1'b1;
            state_next      = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.shift_en  = 1'b1;
        pos_next       = pos + 6'd1;
        mark_done_next = 1'b1;
        if (!mark_done) begin
          ctrl.shift_byte = PAD_MARK;
        end else if (len_phase || pos == LEN_POS) begin
          // length bytes, most significant first
          ctrl.shift_byte = len_bits[63:56];
          len_bits_next   = {len_bits[55:0], 8'h00};
          len_phase_next  = 1'b1;
        end else begin
          ctrl.shift_byte = 8'h00;
        end
        if (pos == LAST_POS) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        ctrl.start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (core_done) begin
          if (len_phase) begin
            out_idx_next = '0;
            state_next   = ST_OUT;
          end else if (pad_active) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_idx == LAST_WORD) begin
            ctrl.init_chain = 1'b1;
            pos_next        = '0;
            len_bits_next   = '0;
            pad_active_next = 1'b0;
            mark_done_next  = 1'b0;
            len_phase_next  = 1'b0;
            out_idx_next    = '0;
            state_next      = ST_IDLE;
          end else begin
            out_idx_next = out_idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while digest pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && pos == 6'd0 && len_bits == 64'd0)
    else $error("state not cleared after digest");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    core_done |-> state == ST_WAIT)
    else $error("compression finished outside wait");

  a_pad_block_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD && pos == LAST_POS |=> state == ST_START)
    else $error("full padded block not compressed");

endmodule
